// File: rtl/core/indexed_min_heap_decrease_key_assert.svh
// Assertion macros used by the heap datapath.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_ASSERT_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imh: implication check failed");
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imh: next-cycle check failed");
`else
`define IMH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IMH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/imh_pkg.sv
// Shared types, codes and constants of the indexed min-heap.
package imh_pkg;

   localparam int NODE_COUNT_DEFAULT = 1024;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int NODE_FIELD_W       = 10;
   localparam int KEY_FIELD_W        = 32;
   localparam int COUNT_FIELD_W      = 11;

   typedef enum logic [1:0] {
      KIND_PUSH     = 2'd0,
      KIND_POP      = 2'd1,
      KIND_CLEAR    = 2'd2,
      KIND_CONTAINS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [NODE_FIELD_W-1:0] node_id;
      logic [KEY_FIELD_W-1:0]  key_in;
   } req_type;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0]  node_out;
      logic [KEY_FIELD_W-1:0]   key_out;
      logic                     present;
      logic [1:0]               status;
      logic [COUNT_FIELD_W-1:0] entry_count;
   } rsp_type;

   // Datapath step selected by the controller each cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_WIPE,
      OP_CAPTURE,
      OP_DECODE,
      OP_LOOK,
      OP_CHECK,
      OP_POP1,
      OP_POP2,
      OP_UP,
      OP_UP1,
      OP_DOWN,
      OP_DOWN1,
      OP_DOWN2,
      OP_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     in_range;
      logic     empty;
      logic     found;
      logic     smaller;
      logic     last_one;
      logic     at_root;
      logic     no_left;
      logic     child_wins;
      logic     up_wins;
      logic     out_free;
      logic     wipe_last;
   } sts_type;

endpackage

// File: rtl/core/indexed_min_heap_decrease_key.sv
// Top level of the indexed binary min-heap with decrease-key.
//
//   channel  direction  payload    handshake
//   req      in         req_type   req_valid / req_stall
//   rsp      out        rsp_type   rsp_valid / rsp_stall
//
// Clear, pop on empty and out-of-range nodes go from decode straight to the result step.
// A contains query or a decrease-key whose key is not smaller first reads the node's slot.
// A push then sifts up level by level until it reaches the root or its parent is not larger.
// A pop moves the last entry to the root and sinks it until no child is smaller.
// After reset every slot of the position memory is cleared while req_stall is held high.
// Each request beat yields one result beat; a waiting result beat only holds the final step.
module indexed_min_heap_decrease_key #(
   parameter int NODE_COUNT = imh_pkg::NODE_COUNT_DEFAULT,
   parameter int KEY_BITS   = imh_pkg::KEY_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  imh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output imh_pkg::rsp_type rsp_data
);
   import imh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   imh_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Memories and sift datapath.
   imh_datapath #(
      .NODE_COUNT (NODE_COUNT),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/imh_datapath.sv
// Heap and position memories, sift registers and the result register.
`include "indexed_min_heap_decrease_key_assert.svh"
module imh_datapath #(
   parameter int NODE_COUNT = imh_pkg::NODE_COUNT_DEFAULT,
   parameter int KEY_BITS   = imh_pkg::KEY_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  imh_pkg::req_type req_data,
   input  imh_pkg::cmd_type cmd,
   output imh_pkg::sts_type sts,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output imh_pkg::rsp_type rsp_data
);
   import imh_pkg::*;

   localparam int SLOT_W = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam int IDX_W  = SLOT_W + 2;
   localparam int LIM_W  = CNT_W + NODE_FIELD_W;
   localparam logic [LIM_W-1:0] NODE_LIMIT = LIM_W'(NODE_COUNT);

   typedef struct packed {
      logic [NODE_FIELD_W-1:0] node;
      logic [KEY_BITS-1:0]     key;
   } entry_type;

   // Memories: heap slots and the slot of each node.
   entry_type         heap_mem [NODE_COUNT];
   logic [SLOT_W-1:0] pos_mem  [NODE_COUNT];

   entry_type         heap_q_ff;
   logic [SLOT_W-1:0] pos_q_ff;

   req_type                 req_ff, req_in;
   logic [CNT_W-1:0]        size_ff, size_in;
   logic [SLOT_W-1:0]       at_ff, at_in;
   entry_type               elem_ff, elem_in;
   entry_type               lch_ff, lch_in;
   logic [NODE_FIELD_W-1:0] res_node_ff, res_node_in;
   logic [KEY_FIELD_W-1:0]  res_key_ff, res_key_in;
   logic                    res_present_ff, res_present_in;
   logic [1:0]              res_status_ff, res_status_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]       wipe_ff, wipe_in;

   logic              heap_rd_en, heap_wr_en, pos_rd_en, pos_wr_en;
   logic [SLOT_W-1:0] heap_rd_addr, heap_wr_addr, pos_rd_addr, pos_wr_addr;
   logic [SLOT_W-1:0] pos_wr_data;
   entry_type         heap_wr_data;

   logic [KEY_BITS-1:0] req_key;
   logic [SLOT_W-1:0]   req_idx, parent, last_slot, child_slot;
   logic [IDX_W-1:0]    left, right;
   logic                in_range, found, smaller, no_left, has_right;
   logic                take_left, take_right, child_wins, up_wins, out_free;
   logic [KEY_BITS-1:0] best_key;
   entry_type           child;

   // Address arithmetic and key compares.
   always_comb begin
      req_key    = KEY_BITS'(req_ff.key_in);
      req_idx    = SLOT_W'(req_ff.node_id);
      in_range   = LIM_W'(req_ff.node_id) < NODE_LIMIT;
      found      = (CNT_W'(pos_q_ff) < size_ff) && (heap_q_ff.node == req_ff.node_id);
      smaller    = req_key < heap_q_ff.key;
      parent     = SLOT_W'((at_ff - SLOT_W'(1)) >> 1);
      last_slot  = SLOT_W'(size_ff - CNT_W'(1));
      left       = {1'b0, at_ff, 1'b1};
      right      = left + IDX_W'(1);
      no_left    = left >= IDX_W'(size_ff);
      has_right  = right < IDX_W'(size_ff);
      up_wins    = elem_ff.key < heap_q_ff.key;
      take_left  = lch_ff.key < elem_ff.key;
      best_key   = take_left ? lch_ff.key : elem_ff.key;
      take_right = has_right && (heap_q_ff.key < best_key);
      child_wins = take_left || take_right;
      child      = take_right ? heap_q_ff : lch_ff;
      child_slot = take_right ? right[SLOT_W-1:0] : left[SLOT_W-1:0];
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Memory port selection per step.
   always_comb begin
      heap_rd_en   = 1'b0;
      heap_rd_addr = '0;
      heap_wr_en   = 1'b0;
      heap_wr_addr = at_ff;
      heap_wr_data = elem_ff;
      pos_rd_en    = 1'b0;
      pos_rd_addr  = req_idx;
      pos_wr_en    = 1'b0;
      pos_wr_addr  = SLOT_W'(elem_ff.node);
      pos_wr_data  = at_ff;
      unique case (cmd.op)
         OP_WIPE: begin
            pos_wr_en   = 1'b1;
            pos_wr_addr = wipe_ff;
            pos_wr_data = '0;
         end
         OP_DECODE: begin
            pos_rd_en  = in_range;
            heap_rd_en = 1'b1;
         end
         OP_LOOK: begin
            heap_rd_en   = 1'b1;
            heap_rd_addr = pos_q_ff;
         end
         OP_POP1: begin
            heap_rd_en   = 1'b1;
            heap_rd_addr = last_slot;
         end
         OP_UP: begin
            if (at_ff == '0) begin
               heap_wr_en = 1'b1;
               pos_wr_en  = 1'b1;
            end else begin
               heap_rd_en   = 1'b1;
               heap_rd_addr = parent;
            end
         end
         OP_UP1: begin
            heap_wr_en = 1'b1;
            pos_wr_en  = 1'b1;
            if (up_wins) begin
               heap_wr_data = heap_q_ff;
               pos_wr_addr  = SLOT_W'(heap_q_ff.node);
            end
         end
         OP_DOWN: begin
            if (no_left) begin
               heap_wr_en = 1'b1;
               pos_wr_en  = 1'b1;
            end else begin
               heap_rd_en   = 1'b1;
               heap_rd_addr = left[SLOT_W-1:0];
            end
         end
         OP_DOWN1: begin
            heap_rd_en   = has_right;
            heap_rd_addr = right[SLOT_W-1:0];
         end
         OP_DOWN2: begin
            heap_wr_en = 1'b1;
            pos_wr_en  = 1'b1;
            if (child_wins) begin
               heap_wr_data = child;
               pos_wr_addr  = SLOT_W'(child.node);
            end
         end
         default: begin
         end
      endcase
   end

   // Next values of the working and result registers.
   always_comb begin
      req_in         = req_ff;
      size_in        = size_ff;
      at_in          = at_ff;
      elem_in        = elem_ff;
      lch_in         = lch_ff;
      res_node_in    = res_node_ff;
      res_key_in     = res_key_ff;
      res_present_in = res_present_ff;
      res_status_in  = res_status_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      wipe_in        = wipe_ff;
      unique case (cmd.op)
         OP_WIPE: wipe_in = wipe_ff + SLOT_W'(1);
         OP_CAPTURE: begin
            req_in         = req_data;
            res_node_in    = '0;
            res_key_in     = '0;
            res_present_in = 1'b0;
            res_status_in  = STATUS_DONE;
         end
         OP_DECODE: begin
            case (req_ff.kind)
               KIND_PUSH:  if (!in_range) res_status_in = STATUS_IGNORED;
               KIND_POP:   if (size_ff == '0) res_status_in = STATUS_EMPTY;
               KIND_CLEAR: size_in = '0;
               default: begin
               end
            endcase
         end
         OP_CHECK: begin
            if (req_ff.kind == KIND_CONTAINS) begin
               res_present_in = found;
            end else if (found) begin
               if (smaller) begin
                  elem_in = '{node: req_ff.node_id, key: req_key};
                  at_in   = pos_q_ff;
               end else begin
                  res_status_in = STATUS_IGNORED;
               end
            end else begin
               elem_in = '{node: req_ff.node_id, key: req_key};
               at_in   = SLOT_W'(size_ff);
               size_in = size_ff + CNT_W'(1);
            end
         end
         OP_POP1: begin
            res_node_in = heap_q_ff.node;
            res_key_in  = KEY_FIELD_W'(heap_q_ff.key);
            size_in     = size_ff - CNT_W'(1);
         end
         OP_POP2: begin
            elem_in = heap_q_ff;
            at_in   = '0;
         end
         OP_UP1:   if (up_wins) at_in = parent;
         OP_DOWN1: lch_in = heap_q_ff;
         OP_DOWN2: if (child_wins) at_in = child_slot;
         OP_LOAD: begin
            if (out_free) begin
               rsp_in.node_out    = res_node_ff;
               rsp_in.key_out     = res_key_ff;
               rsp_in.present     = res_present_ff;
               rsp_in.status      = res_status_ff;
               rsp_in.entry_count = COUNT_FIELD_W'(size_ff);
               rsp_valid_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         wipe_ff      <= '0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         wipe_ff      <= wipe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      at_ff          <= at_in;
      elem_ff        <= elem_in;
      lch_ff         <= lch_in;
      res_node_ff    <= res_node_in;
      res_key_ff     <= res_key_in;
      res_present_ff <= res_present_in;
      res_status_ff  <= res_status_in;
      rsp_ff         <= rsp_in;
   end

   // Heap slot memory with registered read.
   always_ff @(posedge clock) begin
      if (heap_wr_en) heap_mem[heap_wr_addr] <= heap_wr_data;
      if (heap_rd_en) heap_q_ff <= heap_mem[heap_rd_addr];
   end

   // Position memory with registered read.
   always_ff @(posedge clock) begin
      if (pos_wr_en) pos_mem[pos_wr_addr] <= pos_wr_data;
      if (pos_rd_en) pos_q_ff <= pos_mem[pos_rd_addr];
   end

   assign sts = '{kind: kind_type'(req_ff.kind), in_range: in_range,
                  empty: size_ff == '0, found: found, smaller: smaller,
                  last_one: size_ff == CNT_W'(1), at_root: at_ff == '0,
                  no_left: no_left, child_wins: child_wins, up_wins: up_wins,
                  out_free: out_free, wipe_last: wipe_ff == SLOT_W'(NODE_COUNT - 1)};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IMH_ASSERT_IMPL(a_size_bound, clock, reset, 1'b1, size_ff <= CNT_W'(NODE_COUNT))
   `IMH_ASSERT_NEXT(a_pop_shrinks, clock, reset, cmd.op == OP_POP1, size_ff == $past(size_ff) - CNT_W'(1))
   `IMH_ASSERT_IMPL(a_hole_in_heap, clock, reset, cmd.op == OP_UP || cmd.op == OP_DOWN, CNT_W'(at_ff) < size_ff)

endmodule

// File: rtl/core/imh_control.sv
// Sequencer that steps the heap datapath through each operation.
module imh_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  imh_pkg::sts_type sts,
   output imh_pkg::cmd_type cmd
);
   import imh_pkg::*;

   typedef enum logic [3:0] {
      S_WIPE, S_IDLE, S_DECODE, S_LOOK, S_CHECK, S_POP1, S_POP2,
      S_UP, S_UP1, S_DOWN, S_DOWN1, S_DOWN2, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      accept;

   assign accept = req_valid && !req_stall_ff;

   // Next state and datapath step.
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_WIPE: begin
            cmd.op = OP_WIPE;
            if (sts.wipe_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.op = OP_DECODE;
            unique case (sts.kind)
               KIND_POP:   state_in = sts.empty ? S_RESULT : S_POP1;
               KIND_CLEAR: state_in = S_RESULT;
               default:    state_in = sts.in_range ? S_LOOK : S_RESULT;
            endcase
         end
         S_LOOK: begin
            cmd.op   = OP_LOOK;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = OP_CHECK;
            if (sts.kind == KIND_CONTAINS || (sts.found && !sts.smaller)) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_UP;
            end
         end
         S_POP1: begin
            cmd.op   = OP_POP1;
            state_in = sts.last_one ? S_RESULT : S_POP2;
         end
         S_POP2: begin
            cmd.op   = OP_POP2;
            state_in = S_DOWN;
         end
         S_UP: begin
            cmd.op   = OP_UP;
            state_in = sts.at_root ? S_RESULT : S_UP1;
         end
         S_UP1: begin
            cmd.op   = OP_UP1;
            state_in = sts.up_wins ? S_UP : S_RESULT;
         end
         S_DOWN: begin
            cmd.op   = OP_DOWN;
            state_in = sts.no_left ? S_RESULT : S_DOWN1;
         end
         S_DOWN1: begin
            cmd.op   = OP_DOWN1;
            state_in = S_DOWN2;
         end
         S_DOWN2: begin
            cmd.op   = OP_DOWN2;
            state_in = sts.child_wins ? S_DOWN : S_RESULT;
         end
         S_RESULT: begin
            cmd.op = OP_LOAD;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= state_in != S_IDLE;
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// File: test/indexed_min_heap_decrease_key_test.sv
// Self-checking testbench for the indexed min-heap with decrease-key.
module indexed_min_heap_decrease_key_test;
   import imh_pkg::*;

   localparam int NODES = 1024;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   indexed_min_heap_decrease_key u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // Predicted heap contents and position table.
   logic [9:0]  slot_node [NODES];
   logic [31:0] slot_key [NODES];
   int          node_slot [NODES];
   bit          node_held [NODES];
   int          entries;

   rsp_type expected_beats[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off = 1'b0;

   function automatic void exchange_slots(int a, int b);
      logic [9:0]  tn;
      logic [31:0] tk;
      tn = slot_node[a]; tk = slot_key[a];
      slot_node[a] = slot_node[b]; slot_key[a] = slot_key[b];
      slot_node[b] = tn; slot_key[b] = tk;
      node_slot[slot_node[a]] = a;
      node_slot[slot_node[b]] = b;
   endfunction

   function automatic void climb(int at);
      while (at > 0 && slot_key[at] < slot_key[(at - 1) / 2]) begin
         exchange_slots(at, (at - 1) / 2);
         at = (at - 1) / 2;
      end
   endfunction

   function automatic void descend(int at);
      int best;
      forever begin
         best = at;
         if (2 * at + 1 < entries && slot_key[2 * at + 1] < slot_key[best]) best = 2 * at + 1;
         if (2 * at + 2 < entries && slot_key[2 * at + 2] < slot_key[best]) best = 2 * at + 2;
         if (best == at) break;
         exchange_slots(at, best);
         at = best;
      end
   endfunction

   // Computes the heap's answer to one request and updates the model heap.
   function automatic rsp_type heap_answer(req_type r);
      rsp_type a;
      int      at;
      a = '0;
      case (kind_type'(r.kind))
         KIND_PUSH: begin
            if (node_held[r.node_id]) begin
               at = node_slot[r.node_id];
               if (r.key_in < slot_key[at]) begin
                  slot_key[at] = r.key_in;
                  climb(at);
               end else begin
                  a.status = STATUS_IGNORED;
               end
            end else begin
               slot_node[entries] = r.node_id;
               slot_key[entries] = r.key_in;
               node_slot[r.node_id] = entries;
               node_held[r.node_id] = 1'b1;
               entries++;
               climb(entries - 1);
            end
         end
         KIND_POP: begin
            if (entries == 0) begin
               a.status = STATUS_EMPTY;
            end else begin
               a.node_out = slot_node[0];
               a.key_out = slot_key[0];
               node_held[slot_node[0]] = 1'b0;
               entries--;
               if (entries > 0) begin
                  slot_node[0] = slot_node[entries];
                  slot_key[0] = slot_key[entries];
                  node_slot[slot_node[0]] = 0;
                  descend(0);
               end
            end
         end
         KIND_CLEAR: begin
            foreach (node_held[i]) node_held[i] = 1'b0;
            entries = 0;
         end
         default: begin
            a.present = node_held[r.node_id];
         end
      endcase
      a.entry_count = entries[10:0];
      return a;
   endfunction

   // Offers one beat, with a random gap first, and holds it until accepted.
   task automatic send_beat(kind_type k, int node, logic [31:0] key);
      req_type r;
      r.kind = k; r.node_id = node[9:0]; r.key_in = key;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_beats = {expected_beats, heap_answer(r)};
   endtask

   function automatic logic [31:0] random_key();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFFF - $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   // Drops valid and waits until every predicted beat has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // Compares each result beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.node_out !== want.node_out)
               $display("%0t: node_out expected %h actual %h", $time, want.node_out,
                        rsp_data.node_out);
            if (rsp_data.key_out !== want.key_out)
               $display("%0t: key_out expected %h actual %h", $time, want.key_out,
                        rsp_data.key_out);
            if (rsp_data.present !== want.present)
               $display("%0t: present expected %h actual %h", $time, want.present,
                        rsp_data.present);
            if (rsp_data.status !== want.status)
               $display("%0t: status expected %h actual %h", $time, want.status,
                        rsp_data.status);
            if (rsp_data.entry_count !== want.entry_count)
               $display("%0t: entry_count expected %h actual %h", $time,
                        want.entry_count, rsp_data.entry_count);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   // Field extremes, all kinds, empty pops, ignored pushes, clear.
   task automatic test_directed();
      send_beat(KIND_POP, 0, 0);
      send_beat(KIND_CONTAINS, 1023, 0);
      send_beat(KIND_PUSH, 1023, 32'hFFFF_FFFF);
      send_beat(KIND_PUSH, 0, 32'h0000_0000);
      send_beat(KIND_PUSH, 512, 32'h8000_0000);
      send_beat(KIND_PUSH, 341, 32'h5555_5555);
      send_beat(KIND_PUSH, 682, 32'hAAAA_AAAA);
      send_beat(KIND_PUSH, 682, 32'hAAAA_AAAA);
      send_beat(KIND_PUSH, 682, 32'hFFFF_FFFF);
      send_beat(KIND_PUSH, 1023, 32'h0000_0001);
      send_beat(KIND_PUSH, 7, 32'h0000_0001);
      send_beat(KIND_CONTAINS, 1023, 0);
      send_beat(KIND_CONTAINS, 5, 0);
      repeat (4) send_beat(KIND_POP, 0, 0);
      send_beat(KIND_CLEAR, 0, 0);
      send_beat(KIND_CONTAINS, 0, 0);
      send_beat(KIND_POP, 0, 0);
      wait_drained();
   endtask

   // Random pushes, decreases and pops on a node pool of the given size, with contains and clears as noise.
   task automatic test_random(int count, int pool);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 50) send_beat(KIND_PUSH, $urandom_range(pool - 1), random_key());
         else if (pick < 85) send_beat(KIND_POP, $urandom_range(1023), $urandom);
         else if (pick < 97) send_beat(KIND_CONTAINS, $urandom_range(1023), $urandom);
         else send_beat(KIND_CLEAR, $urandom_range(1023), $urandom);
      end
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering, so the block backs up.
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (20) send_beat(KIND_PUSH, $urandom_range(1023), $urandom);
      join
      wait_drained();
      repeat (20) send_beat(KIND_POP, 0, 0);
      wait_drained();
   endtask

   initial begin
      foreach (node_held[i]) node_held[i] = 1'b0;
      entries = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 36; recv_idle_pct = 79;
      test_random(160, 1024);
      send_idle_pct = 79; recv_idle_pct = 36;
      test_random(160, 64);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(160, 32);
      test_backpressure();
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
